// File: design/fpba_pkg.sv
// Package: shared constants, codes and types of the fit policy block allocator.
package fpba_pkg;

    // Table geometry
    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_WIDTH = 16;
    localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

    // Port field widths
    localparam int OP_W      = 1;
    localparam int LIDX_W    = 4;
    localparam int FSIZE_W   = 16;
    localparam int BIDX_W    = 4;
    localparam int POLICY_W  = 2;
    localparam int BCOUNT_W  = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 5;
    localparam int CMP_W     = (CNT_W > BCOUNT_W) ? CNT_W : BCOUNT_W;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 1'b0,
        OP_ALLOC = 1'b1
    } op_t;

    typedef enum logic [POLICY_W-1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2
    } policy_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIT_POLICY  = 1'b0,
        CFG_BLOCK_COUNT = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_WRITE,
        S_RESULT
    } state_t;

    // Configuration seen by the sequencer
    typedef struct packed {
        logic [POLICY_W-1:0] policy;
        logic [CNT_W-1:0]    limit;
    } fpba_cfg_t;

    // One input item
    typedef struct packed {
        logic                op;
        logic [LIDX_W-1:0]   load_index;
        logic [FSIZE_W-1:0]  size_value;
        logic                last_request;
    } fpba_item_t;

    // One result item
    typedef struct packed {
        logic                granted;
        logic [BIDX_W-1:0]   block_index;
        logic [FSIZE_W-1:0]  size_left;
        logic                batch_end;
    } fpba_res_t;

    // Table port requests from the sequencer
    typedef struct packed {
        logic                  we;
        logic [IDX_W-1:0]      waddr;
        logic [SIZE_WIDTH-1:0] wdata;
        logic                  re;
        logic [IDX_W-1:0]      raddr;
    } fpba_ram_req_t;

endpackage

// File: design/fpba_if.sv
// Interfaces: request and response channels with valid/ready handshake.
interface fpba_req_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [fpba_pkg::LIDX_W-1:0]   load_index;
    logic [fpba_pkg::FSIZE_W-1:0]  size_value;
    logic                          last_request;

    modport source (output valid, output op, output load_index, output size_value,
                    output last_request, input ready);
    modport sink   (input valid, input op, input load_index, input size_value,
                    input last_request, output ready);
endinterface

interface fpba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          granted;
    logic [fpba_pkg::BIDX_W-1:0]   block_index;
    logic [fpba_pkg::FSIZE_W-1:0]  size_left;
    logic                          batch_end;

    modport source (output valid, output granted, output block_index, output size_left,
                    output batch_end, input ready);
    modport sink   (input valid, input granted, input block_index, input size_left,
                    input batch_end, output ready);
endinterface

// File: design/fit_policy_block_allocator.sv
// Top level: fit policy block allocator with config registers and response register.
// Flow, accept to response valid: a load writes its table entry, then the result is registered;
// an allocate reads min(block_count,NUM_BLOCKS) entries, compares each read, ends the scan,
// writes back the chosen entry if granted, then registers the result. Throughput: one item
// at a time; the next request is taken while a response waits.
// Reset: rst_n clears sequencer, response register and config; the size table is not cleared.
module fit_policy_block_allocator (
    input  logic                              clk,
    input  logic                              rst_n,
    fpba_req_if.sink                          request,
    fpba_rsp_if.source                        response,
    input  logic                              cfg_we,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import fpba_pkg::*;

    logic [POLICY_W-1:0] policy_reg;
    logic [BCOUNT_W-1:0] count_reg;
    fpba_cfg_t           cfg;

    fpba_item_t          item;
    logic                res_valid;
    logic                res_ready;
    fpba_res_t           res;
    fpba_ram_req_t       ram_req;
    logic [SIZE_WIDTH-1:0] ram_rdata;

    logic                out_valid_reg;
    fpba_res_t           out_reg;

    // Config registers: the user must write them only while the block is idle; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_FIRST;
            count_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIT_POLICY:  policy_reg <= cfg_wdata[POLICY_W-1:0];
                CFG_BLOCK_COUNT: count_reg  <= cfg_wdata[BCOUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Clamp the scan length to the table size
    assign cfg.policy = policy_reg;
    assign cfg.limit  = (CMP_W'(count_reg) > CMP_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                                   : CNT_W'(count_reg);

    assign item.op           = request.op;
    assign item.load_index   = request.load_index;
    assign item.size_value   = request.size_value;
    assign item.last_request = request.last_request;

    fpba_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (request.valid),
        .item_ready (request.ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata)
    );

    // Remaining free size of each block
    fpba_ram #(
        .DEPTH (NUM_BLOCKS),
        .WIDTH (SIZE_WIDTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // Response register: hold a beat until taken, refill in the same cycle it drains
    assign res_ready = !out_valid_reg || response.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign response.valid       = out_valid_reg;
    assign response.granted     = out_reg.granted;
    assign response.block_index = out_reg.block_index;
    assign response.size_left   = out_reg.size_left;
    assign response.batch_end   = out_reg.batch_end;

    // A finished result waits in the sequencer while the response register is blocked
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("sequencer dropped a pending result");

    // No table write while a new request can be taken
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> !request.ready)
        else $error("table written while sequencer idle");

    // A refused or load response carries zero index and size
    a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        response.valid && !response.granted |->
            response.block_index == '0 && response.size_left == '0)
        else $error("refused response carries payload");
endmodule

// File: design/fpba_ram.sv
// Generic single write port, single read port RAM with registered read data.
module fpba_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: design/fpba_seq.sv
// Sequencer: takes one item; writes a load, or scans and writes back the pick.
module fpba_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fpba_pkg::fpba_cfg_t         cfg,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  fpba_pkg::fpba_item_t        item,
    output logic                        res_valid,
    input  logic                        res_ready,
    output fpba_pkg::fpba_res_t         res,
    output fpba_pkg::fpba_ram_req_t     ram_req,
    input  logic [fpba_pkg::SIZE_WIDTH-1:0] ram_rdata
);
    import fpba_pkg::*;

    state_t                state_reg, state_next;
    fpba_item_t            item_reg, item_next;
    logic [CNT_W-1:0]      scan_reg, scan_next;
    logic                  chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]      chk_idx_reg, chk_idx_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      pick_idx_reg, pick_idx_next;
    logic [SIZE_WIDTH-1:0] pick_size_reg, pick_size_next;

    logic [SIZE_WIDTH-1:0] req_size;
    logic                  issue;
    logic                  fits;
    logic                  better;

    assign req_size = SIZE_WIDTH'(item_reg.size_value);
    assign issue    = (scan_reg < cfg.limit);
    assign fits     = (ram_rdata >= req_size);

    always_comb
    begin
        priority if (!found_reg)
            better = 1'b1;
        else if (cfg.policy == POL_BEST)
            better = (ram_rdata < pick_size_reg);
        else if (cfg.policy == POL_WORST)
            better = (ram_rdata > pick_size_reg);
        else
            better = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chk_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        scan_reg      <= scan_next;
        chk_idx_reg   <= chk_idx_next;
        pick_idx_reg  <= pick_idx_next;
        pick_size_reg <= pick_size_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        scan_next      = scan_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        found_next     = found_reg;
        pick_idx_next  = pick_idx_reg;
        pick_size_next = pick_size_reg;
        item_ready     = 1'b0;
        res_valid      = 1'b0;
        ram_req        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    item_next  = item;
                    scan_next  = '0;
                    found_next = 1'b0;
                    state_next = (item.op == OP_ALLOC) ? S_SCAN : S_LOAD;
                end
            end
            S_LOAD:
            begin
                // drop loads beyond the table
                ram_req.we    = (32'(item_reg.load_index) < NUM_BLOCKS);
                ram_req.waddr = IDX_W'(item_reg.load_index);
                ram_req.wdata = req_size;
                state_next    = S_RESULT;
            end
            S_SCAN:
            begin
                ram_req.re    = issue;
                ram_req.raddr = scan_reg[IDX_W-1:0];
                if (issue)
                begin
                    scan_next      = scan_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_reg[IDX_W-1:0];
                end
                if (chk_valid_reg && fits && better)
                begin
                    found_next     = 1'b1;
                    pick_idx_next  = chk_idx_reg;
                    pick_size_next = ram_rdata;
                end
                if (!issue && !chk_valid_reg)
                begin
                    state_next = found_reg ? S_WRITE : S_RESULT;
                end
            end
            S_WRITE:
            begin
                ram_req.we     = 1'b1;
                ram_req.waddr  = pick_idx_reg;
                ram_req.wdata  = pick_size_reg - req_size;
                pick_size_next = pick_size_reg - req_size;
                state_next     = S_RESULT;
            end
            S_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.granted     = (item_reg.op == OP_ALLOC) && found_reg;
        res.block_index = res.granted ? BIDX_W'(pick_idx_reg) : '0;
        res.size_left   = res.granted ? FSIZE_W'(pick_size_reg) : '0;
        res.batch_end   = item_reg.last_request;
    end
endmodule
